/* rtl/rgbled_pkg.sv */
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, constants and helpers for the LED strip frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbled_pkg;

  // Store size and derived index width
  localparam int MAX_LEDS   = 32;
  localparam int LED_IDX_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // Field and register widths
  localparam int CNT_W      = 6;
  localparam int ENDS_W     = $clog2((MAX_LEDS + 15) / 16 + 1);
  localparam int POS_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int COLOUR_W   = 24;
  localparam int FRAME_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Register reset values
  localparam logic [CNT_W-1:0] NUM_LEDS_RST  = 6'd11;
  localparam logic [POS_W-1:0] RED_POS_RST   = 2'd0;
  localparam logic [POS_W-1:0] GREEN_POS_RST = 2'd2;
  localparam logic [POS_W-1:0] BLUE_POS_RST  = 2'd1;

  // Fixed frame contents
  localparam logic [FRAME_W-1:0] START_FRAME = 32'h0000_0000;
  localparam logic [FRAME_W-1:0] END_FRAME   = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0]  BRIGHT_BYTE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_LEDS  = 2'd0,
    CFG_RED_POS   = 2'd1,
    CFG_GREEN_POS = 2'd2,
    CFG_BLUE_POS  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_SET    = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_LED   = 2'd1,
    KIND_END   = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic              cmd;
    logic [4:0]        led_index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_word;
    logic [1:0]         frame_kind;
    logic               last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                 wr_en;
    logic [LED_IDX_W-1:0] rd_addr;
    logic                 emit;
    frame_kind_t          kind;
    logic                 last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [ENDS_W-1:0] ends;
  } dp_stat_t;

  // Pack the three colour bytes; position three falls off the entry
  function automatic logic [COLOUR_W-1:0] pack_colour(
    input logic [BYTE_W-1:0] red,
    input logic [BYTE_W-1:0] green,
    input logic [BYTE_W-1:0] blue,
    input logic [POS_W-1:0]  red_pos,
    input logic [POS_W-1:0]  green_pos,
    input logic [POS_W-1:0]  blue_pos
  );
    logic [COLOUR_W-1:0] colour;
    colour = '0;
    for (int p = 0; p < 3; p++) begin
      if (red_pos == POS_W'(p))   colour[p*BYTE_W +: BYTE_W] |= red;
      if (green_pos == POS_W'(p)) colour[p*BYTE_W +: BYTE_W] |= green;
      if (blue_pos == POS_W'(p))  colour[p*BYTE_W +: BYTE_W] |= blue;
    end
    return colour;
  endfunction

  // LED frame: brightness byte, then colour bytes low to high
  function automatic logic [FRAME_W-1:0] led_frame(input logic [COLOUR_W-1:0] colour);
    return {BRIGHT_BYTE, colour[7:0], colour[15:8], colour[23:16]};
  endfunction

endpackage

`default_nettype wire

/* rtl/rgbled_ctrl.sv */
// ----------------------------------------------------------------------------
// rgbled_ctrl
// Command sequencer: takes set and update commands and walks the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbled_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_cmd,
  input  wire rgbled_pkg::dp_stat_t stat,
  output logic                     busy,
  output rgbled_pkg::dp_cmd_t      dp_cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_LEDS = 4'b0100,
    ST_TAIL = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [rgbled_pkg::CNT_W-1:0]      idx_r, idx_nxt;
  logic [rgbled_pkg::ENDS_W-1:0]     end_cnt_r, end_cnt_nxt;
  logic [rgbled_pkg::CNT_W-1:0]      idx_inc;
  logic [rgbled_pkg::ENDS_W-1:0]     end_inc;
  logic                              accept;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign idx_inc = rgbled_pkg::CNT_W'(idx_r + 1'b1);
  assign end_inc = rgbled_pkg::ENDS_W'(end_cnt_r + 1'b1);

  // Next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    end_cnt_nxt    = end_cnt_r;
    dp_cmd.wr_en   = 1'b0;
    dp_cmd.rd_addr = '0;
    dp_cmd.emit    = 1'b0;
    dp_cmd.kind    = rgbled_pkg::KIND_START;
    dp_cmd.last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == rgbled_pkg::CMD_SET) begin
            dp_cmd.wr_en = 1'b1;
          end else begin
            state_nxt   = ST_HEAD;
            idx_nxt     = '0;
            end_cnt_nxt = '0;
          end
        end
      end
      ST_HEAD: begin
        dp_cmd.emit    = 1'b1;
        dp_cmd.kind    = rgbled_pkg::KIND_START;
        dp_cmd.last    = (stat.count == '0);
        dp_cmd.rd_addr = '0;
        state_nxt      = (stat.count == '0) ? ST_IDLE : ST_LEDS;
      end
      ST_LEDS: begin
        // Fetch the next entry while this one goes out
        dp_cmd.emit    = 1'b1;
        dp_cmd.kind    = rgbled_pkg::KIND_LED;
        dp_cmd.rd_addr = idx_inc[rgbled_pkg::LED_IDX_W-1:0];
        if (idx_inc == stat.count) begin
          state_nxt = ST_TAIL;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_TAIL: begin
        dp_cmd.emit = 1'b1;
        dp_cmd.kind = rgbled_pkg::KIND_END;
        dp_cmd.last = (end_inc == stat.ends);
        if (end_inc == stat.ends) begin
          state_nxt = ST_IDLE;
        end else begin
          end_cnt_nxt = end_inc;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      end_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      end_cnt_r <= end_cnt_nxt;
    end
  end

  // An accepted update always opens with the start word
  a_update_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == rgbled_pkg::CMD_UPDATE) |=> state_r == ST_HEAD)
    else $error("update did not enter header state");

  // The final word of an update returns the sequencer to idle
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.emit && dp_cmd.last) |=> state_r == ST_IDLE)
    else $error("sequencer still busy after last word");

  // The LED walk is only entered from the header or continued
  a_leds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEDS) |->
      ($past(state_r) == ST_HEAD || $past(state_r) == ST_LEDS))
    else $error("LED walk entered out of order");

  // Sets only happen while idle
  a_set_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.wr_en |-> (!busy && !dp_cmd.emit))
    else $error("store write during frame walk");

endmodule

`default_nettype wire

/* rtl/rgbled_dp.sv */
// ----------------------------------------------------------------------------
// rgbled_dp
// Datapath: registers, colour store and the registered frame output.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbled_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [rgbled_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rgbled_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire rgbled_pkg::in_word_t                  in_word,
  input  wire rgbled_pkg::dp_cmd_t                   dp_cmd,
  output rgbled_pkg::dp_stat_t                       stat,
  output logic                                       out_valid,
  output rgbled_pkg::out_word_t                      out_word
);

  logic [rgbled_pkg::CNT_W-1:0]    num_leds_r;
  logic [rgbled_pkg::POS_W-1:0]    red_pos_r;
  logic [rgbled_pkg::POS_W-1:0]    green_pos_r;
  logic [rgbled_pkg::POS_W-1:0]    blue_pos_r;

  logic [rgbled_pkg::COLOUR_W-1:0] colour_mem [rgbled_pkg::MAX_LEDS];
  logic [rgbled_pkg::MAX_LEDS-1:0] vld_r;
  logic [rgbled_pkg::COLOUR_W-1:0] rd_colour_r;
  logic                            rd_vld_r;

  logic [rgbled_pkg::CNT_W-1:0]    count;
  logic [rgbled_pkg::CNT_W:0]      ends_sum;
  logic                            wr_ok;
  logic [rgbled_pkg::LED_IDX_W-1:0] wr_addr;
  logic [rgbled_pkg::COLOUR_W-1:0] wr_colour;
  logic [rgbled_pkg::COLOUR_W-1:0] led_colour;
  logic [rgbled_pkg::FRAME_W-1:0]  frame_nxt;

  logic                            out_valid_r;
  rgbled_pkg::out_word_t           out_word_r;

  // Clamp the count to the store size; one end word per sixteen LEDs
  assign count = (num_leds_r > rgbled_pkg::CNT_W'(rgbled_pkg::MAX_LEDS))
               ? rgbled_pkg::CNT_W'(rgbled_pkg::MAX_LEDS) : num_leds_r;
  assign ends_sum   = {1'b0, count} + (rgbled_pkg::CNT_W+1)'(15);
  assign stat.count = count;
  assign stat.ends  = rgbled_pkg::ENDS_W'(ends_sum >> 4);

  // Drop sets at or beyond the active count
  assign wr_ok     = dp_cmd.wr_en && ({1'b0, in_word.led_index} < count);
  assign wr_addr   = rgbled_pkg::LED_IDX_W'(in_word.led_index);
  assign wr_colour = rgbled_pkg::pack_colour(in_word.red, in_word.green, in_word.blue,
                                             red_pos_r, green_pos_r, blue_pos_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_leds_r  <= rgbled_pkg::NUM_LEDS_RST;
      red_pos_r   <= rgbled_pkg::RED_POS_RST;
      green_pos_r <= rgbled_pkg::GREEN_POS_RST;
      blue_pos_r  <= rgbled_pkg::BLUE_POS_RST;
    end else if (cfg_we) begin
      unique case (rgbled_pkg::cfg_reg_t'(cfg_index))
        rgbled_pkg::CFG_NUM_LEDS:  num_leds_r  <= cfg_data;
        rgbled_pkg::CFG_RED_POS:   red_pos_r   <= cfg_data[rgbled_pkg::POS_W-1:0];
        rgbled_pkg::CFG_GREEN_POS: green_pos_r <= cfg_data[rgbled_pkg::POS_W-1:0];
        rgbled_pkg::CFG_BLUE_POS:  blue_pos_r  <= cfg_data[rgbled_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry valid bits: an unwritten entry reads as black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_ok) vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= vld_r[dp_cmd.rd_addr];
    end
  end

  // Colour store, registered read
  always_ff @(posedge clk) begin
    if (wr_ok) colour_mem[wr_addr] <= wr_colour;
    rd_colour_r <= colour_mem[dp_cmd.rd_addr];
  end

  assign led_colour = rd_vld_r ? rd_colour_r : '0;

  // Select the outgoing frame word
  always_comb begin
    case (dp_cmd.kind)
      rgbled_pkg::KIND_LED: frame_nxt = rgbled_pkg::led_frame(led_colour);
      rgbled_pkg::KIND_END: frame_nxt = rgbled_pkg::END_FRAME;
      default:              frame_nxt = rgbled_pkg::START_FRAME;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.frame_word <= frame_nxt;
    out_word_r.frame_kind <= dp_cmd.kind;
    out_word_r.last       <= dp_cmd.last;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* rtl/rgb_led_strip_frame_encoder_core.sv */
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_encoder_core
// Stores one colour per LED and streams the strip's frame words on update.
// ----------------------------------------------------------------------------
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------
//  input    | start, busy, in_word           | word taken when start & !busy
//  result   | out_valid, out_word            | one-cycle strobe, no back-off
//  config   | cfg_we, cfg_index, cfg_data    | write on cfg_we, no wait
//
//  A set word leaves the sequencer idle; the next word may follow at once.
//  During an update the sequencer emits one word per cycle, reading
//  LED colours from the colour store's read port.
//  Results leave through an output register, in the cycle after the sequencer emits them.
//  Reset is synchronous; all store entries read as zero until written.
//  The receiver cannot stall, so no word is ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_strip_frame_encoder_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire rgbled_pkg::in_word_t              in_word,
  output logic                                   out_valid,
  output rgbled_pkg::out_word_t                  out_word,
  input  wire logic                              cfg_we,
  input  wire logic [rgbled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rgbled_pkg::CFG_DATA_W-1:0] cfg_data
);

  rgbled_pkg::dp_cmd_t  dp_cmd;
  rgbled_pkg::dp_stat_t stat;

  // Sequencer
  rgbled_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_word.cmd),
    .stat   (stat),
    .busy   (busy),
    .dp_cmd (dp_cmd)
  );

  // Store and frame datapath
  rgbled_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .dp_cmd    (dp_cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* test/rgb_led_strip_frame_encoder_core_tb.sv */
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_encoder_core_tb
// Drives set and update words into the LED strip frame encoder and checks each
// frame word against an in-bench model of the colour store and framing. The
// model tracks register writes and accepted words at the clock edge. Directed
// tests cover colour order, index range, position three, shared positions and
// count extremes. Random phases follow under several sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_led_strip_frame_encoder_core_tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_GAP       = 20;
  localparam int PHASE_WORDS   = 55;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              start     = 1'b0;
  rgbled_pkg::in_word_t              in_word   = '0;
  logic                              cfg_we    = 1'b0;
  logic [rgbled_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rgbled_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                              busy;
  logic                              out_valid;
  rgbled_pkg::out_word_t             out_word;

  // Model copy of the registers and the colour store
  logic [rgbled_pkg::CNT_W-1:0]    strip_len;
  logic [rgbled_pkg::POS_W-1:0]    red_slot;
  logic [rgbled_pkg::POS_W-1:0]    green_slot;
  logic [rgbled_pkg::POS_W-1:0]    blue_slot;
  logic [rgbled_pkg::COLOUR_W-1:0] colour_store [rgbled_pkg::MAX_LEDS];

  rgbled_pkg::out_word_t frame_words_due[$];
  int        mismatches   = 0;
  int        idle_pct     = 0;
  int        stall_cycles = 0;

  rgb_led_strip_frame_encoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // LEDs actually walked: the count saturates at the store size
  function automatic int lit_leds();
    return (int'(strip_len) > rgbled_pkg::MAX_LEDS) ? rgbled_pkg::MAX_LEDS
                                                    : int'(strip_len);
  endfunction

  // Place one colour byte; slot three lies outside the entry
  function automatic logic [rgbled_pkg::COLOUR_W-1:0] slot_byte(
    input logic [rgbled_pkg::BYTE_W-1:0] b,
    input logic [rgbled_pkg::POS_W-1:0]  slot);
    case (slot)
      2'd0: return {16'h0000, b};
      2'd1: return {8'h00, b, 8'h00};
      2'd2: return {b, 16'h0000};
      default: return '0;
    endcase
  endfunction

  // Apply one accepted word: store a colour, or queue the whole frame
  function automatic void encode_word(input rgbled_pkg::in_word_t w);
    int                              n;
    int                              ends;
    rgbled_pkg::out_word_t           fw;
    logic [rgbled_pkg::COLOUR_W-1:0] c;
    n = lit_leds();
    if (w.cmd == rgbled_pkg::CMD_SET) begin
      if (int'(w.led_index) < n) begin
        colour_store[w.led_index] = slot_byte(w.red, red_slot) |
                                    slot_byte(w.green, green_slot) |
                                    slot_byte(w.blue, blue_slot);
      end
      return;
    end
    fw.frame_word = rgbled_pkg::START_FRAME;
    fw.frame_kind = rgbled_pkg::KIND_START;
    fw.last       = (n == 0);
    frame_words_due.push_back(fw);
    for (int i = 0; i < n; i++) begin
      c = colour_store[i];
      fw.frame_word = {rgbled_pkg::BRIGHT_BYTE, c[7:0], c[15:8], c[23:16]};
      fw.frame_kind = rgbled_pkg::KIND_LED;
      fw.last       = 1'b0;
      frame_words_due.push_back(fw);
    end
    ends = (n + 15) / 16;
    for (int j = 0; j < ends; j++) begin
      fw.frame_word = rgbled_pkg::END_FRAME;
      fw.frame_kind = rgbled_pkg::KIND_END;
      fw.last       = (j == ends - 1);
      frame_words_due.push_back(fw);
    end
  endfunction

  // Track register writes and accepted words
  always @(posedge clk) begin
    if (!rst_n) begin
      strip_len  = rgbled_pkg::NUM_LEDS_RST;
      red_slot   = rgbled_pkg::RED_POS_RST;
      green_slot = rgbled_pkg::GREEN_POS_RST;
      blue_slot  = rgbled_pkg::BLUE_POS_RST;
      for (int i = 0; i < rgbled_pkg::MAX_LEDS; i++) colour_store[i] = '0;
    end else begin
      if (cfg_we) begin
        case (rgbled_pkg::cfg_reg_t'(cfg_index))
          rgbled_pkg::CFG_NUM_LEDS:  strip_len  = cfg_data[rgbled_pkg::CNT_W-1:0];
          rgbled_pkg::CFG_RED_POS:   red_slot   = cfg_data[rgbled_pkg::POS_W-1:0];
          rgbled_pkg::CFG_GREEN_POS: green_slot = cfg_data[rgbled_pkg::POS_W-1:0];
          rgbled_pkg::CFG_BLUE_POS:  blue_slot  = cfg_data[rgbled_pkg::POS_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) encode_word(in_word);
    end
  end

  // Compare each frame word with the oldest one due
  always @(posedge clk) begin
    rgbled_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (frame_words_due.size() == 0) begin
        $display("%0t: unexpected word, got %h/%0d/%0b", $time,
                 out_word.frame_word, out_word.frame_kind, out_word.last);
        mismatches++;
      end else begin
        want = frame_words_due.pop_front();
        if (want !== out_word) begin
          $display("%0t: word mismatch, expected %h/%0d/%0b, got %h/%0d/%0b", $time,
                   want.frame_word, want.frame_kind, want.last,
                   out_word.frame_word, out_word.frame_kind, out_word.last);
          mismatches++;
        end
      end
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("rgb_led_strip_frame_encoder_core_tb: errors");
        $finish;
      end
    end
  end

  // Hold start high with the word until it is taken, after a random gap
  task automatic send_word(input rgbled_pkg::in_word_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_led(input int idx, input int r, input int g, input int b);
    rgbled_pkg::in_word_t w;
    w.cmd       = rgbled_pkg::CMD_SET;
    w.led_index = idx[4:0];
    w.red       = r[7:0];
    w.green     = g[7:0];
    w.blue      = b[7:0];
    send_word(w);
  endtask

  // Colour fields carry noise; the block must ignore them on update
  task automatic update_strip();
    rgbled_pkg::in_word_t w;
    w.cmd       = rgbled_pkg::CMD_UPDATE;
    w.led_index = 5'($urandom);
    w.red       = rgbled_pkg::BYTE_W'($urandom);
    w.green     = rgbled_pkg::BYTE_W'($urandom);
    w.blue      = rgbled_pkg::BYTE_W'($urandom);
    send_word(w);
  endtask

  // Drop start and wait for every frame word due, then let the block settle
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (frame_words_due.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int num, input int rpos, input int gpos,
                              input int bpos);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= rgbled_pkg::CFG_NUM_LEDS;
    cfg_data  <= rgbled_pkg::CFG_DATA_W'(num);
    @(posedge clk);
    cfg_index <= rgbled_pkg::CFG_RED_POS;
    cfg_data  <= rgbled_pkg::CFG_DATA_W'(rpos);
    @(posedge clk);
    cfg_index <= rgbled_pkg::CFG_GREEN_POS;
    cfg_data  <= rgbled_pkg::CFG_DATA_W'(gpos);
    @(posedge clk);
    cfg_index <= rgbled_pkg::CFG_BLUE_POS;
    cfg_data  <= rgbled_pkg::CFG_DATA_W'(bpos);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Frame straight out of reset: eleven dark LEDs
  task automatic test_reset_frame();
    update_strip();
  endtask

  // Byte extremes through the reset colour order
  task automatic test_colour_order();
    set_led(0, 8'hFF, 8'h00, 8'h00);
    set_led(10, 8'h00, 8'hFF, 8'h00);
    set_led(5, 8'h00, 8'h00, 8'hFF);
    set_led(3, 8'hA5, 8'h5A, 8'hC3);
    update_strip();
  endtask

  // Indexes at and above the count leave the store alone
  task automatic test_index_range();
    set_led(11, 8'h11, 8'h22, 8'h33);
    set_led(31, 8'hFF, 8'hFF, 8'hFF);
    set_led(10, 8'hFF, 8'hFF, 8'hFF);
    update_strip();
  endtask

  // Position three drops a byte; shared positions merge bytes
  task automatic test_positions();
    program_regs(4, 3, 0, 0);
    set_led(0, 8'hFF, 8'h0F, 8'hF0);
    set_led(3, 8'h12, 8'h34, 8'h56);
    update_strip();
    program_regs(4, 1, 1, 3);
    set_led(1, 8'h81, 8'h42, 8'hFF);
    update_strip();
  endtask

  // Zero count, saturated count and both end-word cases
  task automatic test_count_extremes();
    program_regs(0, 0, 1, 2);
    set_led(0, 8'h55, 8'hAA, 8'h77);
    update_strip();
    program_regs(63, 2, 1, 0);
    set_led(31, 8'hDE, 8'hAD, 8'hBE);
    set_led(0, 8'h01, 8'h80, 8'h7F);
    update_strip();
    program_regs(1, 0, 2, 1);
    update_strip();
    program_regs(17, 0, 2, 1);
    update_strip();
    program_regs(32, 1, 2, 0);
    update_strip();
  endtask

  // Random phases: mostly in-range sets, some stray indexes, frequent updates
  task automatic test_random();
    int n;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 60;
        default: idle_pct = 19;
      endcase
      case (phase)
        0: program_regs(32, 0, 1, 2);
        1: program_regs(1, 2, 1, 0);
        default: begin
          if ($urandom_range(3) == 0) n = $urandom_range(0, 63);
          else n = $urandom_range(1, 32);
          program_regs(n, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
        end
      endcase
      n = lit_leds();
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(99) < 80) begin
          if (n > 0 && $urandom_range(9) < 8)
            set_led($urandom_range(0, n - 1), $urandom, $urandom, $urandom);
          else
            set_led($urandom_range(0, 31), $urandom, $urandom, $urandom);
        end else begin
          update_strip();
        end
        if ($urandom_range(99) < 3) wait_drained();
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_frame();
    test_colour_order();
    test_index_range();
    test_positions();
    test_count_extremes();
    test_random();
    wait_drained();
    if (mismatches == 0 && frame_words_due.size() == 0) begin
      $display("rgb_led_strip_frame_encoder_core_tb: clean");
    end else begin
      $display("rgb_led_strip_frame_encoder_core_tb: errors");
    end
    $finish;
  end

endmodule

/* rgb_led_strip_frame_encoder_core.f */
rtl/rgbled_pkg.sv
rtl/rgbled_ctrl.sv
rtl/rgbled_dp.sv
rtl/rgb_led_strip_frame_encoder_core.sv
test/rgb_led_strip_frame_encoder_core_tb.sv
